/* rtl/core/bsl_pkg.sv */
// shared types, character codes and classification functions for the byte stream lexer
package bsl_pkg;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_IDENT     = 4'd1,
    ST_STR_DQ    = 4'd2,
    ST_STR_SQ    = 4'd3,
    ST_ESC_DQ    = 4'd4,
    ST_ESC_SQ    = 4'd5,
    ST_DASH      = 4'd6,
    ST_LBRACE    = 4'd7,
    ST_SEL       = 4'd8,
    ST_SEL_CLOSE = 4'd9
  } lex_state_t;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_SYMBOL   = 3'd0;
  localparam kind_t KIND_STRING   = 3'd1;
  localparam kind_t KIND_IDENT    = 3'd2;
  localparam kind_t KIND_VIR      = 3'd3;
  localparam kind_t KIND_SELECTOR = 3'd4;
  localparam kind_t KIND_ARROW    = 3'd5;

  // progress through the keyword "vir"
  typedef logic [2:0] kw_prog_t;

  localparam kw_prog_t KW_NONE = 3'd0;
  localparam kw_prog_t KW_V    = 3'd1;
  localparam kw_prog_t KW_VI   = 3'd2;
  localparam kw_prog_t KW_VIR  = 3'd3;
  localparam kw_prog_t KW_MISS = 3'd4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_R      = 8'h72;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [16:0] len;
    logic        last;
  } token_rec_t;

  // up to two token records produced by one byte
  typedef struct packed {
    logic       v0;
    logic       v1;
    token_rec_t rec0;
    token_rec_t rec1;
  } token_push_t;

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_id_start(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
           (b == CH_UNDER) || (b == CH_DOLLAR);
  endfunction

  function automatic logic is_id_part(logic [7:0] b);
    return is_id_start(b) || (b >= 8'h30 && b <= 8'h39) || (b == CH_DASH);
  endfunction

  function automatic logic is_symbol(logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
           (b == CH_RPAREN) || (b == CH_LBRACK) || (b == CH_RBRACK) ||
           (b == CH_SEMI) || (b == CH_COLON) || (b == CH_EQUAL) ||
           (b == CH_COMMA) || (b == CH_DOT);
  endfunction

endpackage

/* rtl/core/bsl_core.sv */
// lexer state registers and the single-pass per-byte next-state and token logic
module bsl_core #(
  parameter int MAX_CONTENT     = 65536,
  parameter int MAX_BRACE_DEPTH = 255
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                step_en,
  input  logic [7:0]          data_byte,
  input  logic                end_of_content,
  output bsl_pkg::token_push_t push
);

  localparam int OFF_W = $clog2(MAX_CONTENT);
  localparam int DEP_W = $clog2(MAX_BRACE_DEPTH + 1);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(MAX_CONTENT - 1);
  localparam logic [DEP_W-1:0] DEP_MAX  = DEP_W'(MAX_BRACE_DEPTH);
  localparam logic [DEP_W-1:0] DEP_OPEN = DEP_W'(2);

  logic                 mode_r;
  bsl_pkg::lex_state_t  st_r, st_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [OFF_W-1:0]     ts_r, ts_nxt;
  logic [DEP_W-1:0]     dep_r, dep_nxt;
  bsl_pkg::kw_prog_t    kwp_r, kwp_nxt;

  function automatic bsl_pkg::token_rec_t mk_rec(bsl_pkg::kind_t k,
                                                 logic [OFF_W-1:0] s,
                                                 logic [OFF_W:0] e);
    bsl_pkg::token_rec_t r;
    logic [OFF_W:0]      s_x;
    logic [OFF_W:0]      d;
    s_x    = {1'b0, s};
    d      = e - s_x;
    r.kind  = k;
    r.start = 16'(s);
    r.len   = (e > s_x) ? 17'(d) : 17'd1;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic bsl_pkg::kind_t ident_kind(logic m, bsl_pkg::kw_prog_t p);
    return (m && p == bsl_pkg::KW_VIR) ? bsl_pkg::KIND_VIR : bsl_pkg::KIND_IDENT;
  endfunction

  always_comb begin
    logic [OFF_W:0]       pos0;
    logic [OFF_W:0]       pos1;
    logic [DEP_W-1:0]     dn;
    logic                 relex;
    logic                 e1, e2, e3, has2;
    bsl_pkg::token_rec_t  r1, r2, r3, second;
    bsl_pkg::lex_state_t  st_mid;
    logic [OFF_W-1:0]     ts_mid;
    logic [DEP_W-1:0]     dep_mid;
    bsl_pkg::kw_prog_t    kwp_mid;

    pos0    = {1'b0, off_r};
    pos1    = {1'b0, off_r} + (OFF_W+1)'(1);
    dn      = dep_r;
    relex   = 1'b0;
    e1      = 1'b0;
    e2      = 1'b0;
    e3      = 1'b0;
    r1      = '0;
    r2      = '0;
    r3      = '0;
    st_mid  = st_r;
    ts_mid  = ts_r;
    dep_mid = dep_r;
    kwp_mid = kwp_r;

    // continue the open token
    case (st_r)
      bsl_pkg::ST_IDENT: begin
        if (bsl_pkg::is_id_part(data_byte)) begin
          if (kwp_r == bsl_pkg::KW_V && data_byte == bsl_pkg::CH_I) begin
            kwp_mid = bsl_pkg::KW_VI;
          end else if (kwp_r == bsl_pkg::KW_VI && data_byte == bsl_pkg::CH_R) begin
            kwp_mid = bsl_pkg::KW_VIR;
          end else begin
            kwp_mid = bsl_pkg::KW_MISS;
          end
        end else begin
          e1    = 1'b1;
          r1    = mk_rec(ident_kind(mode_r, kwp_r), ts_r, pos0);
          relex = 1'b1;
        end
      end
      bsl_pkg::ST_STR_DQ: begin
        if (data_byte == bsl_pkg::CH_DQUOTE) begin
          e1     = 1'b1;
          r1     = mk_rec(bsl_pkg::KIND_STRING, ts_r, pos1);
          st_mid = bsl_pkg::ST_IDLE;
        end else if (data_byte == bsl_pkg::CH_BSLASH) begin
          st_mid = bsl_pkg::ST_ESC_DQ;
        end
      end
      bsl_pkg::ST_STR_SQ: begin
        if (data_byte == bsl_pkg::CH_SQUOTE) begin
          e1     = 1'b1;
          r1     = mk_rec(bsl_pkg::KIND_STRING, ts_r, pos1);
          st_mid = bsl_pkg::ST_IDLE;
        end else if (data_byte == bsl_pkg::CH_BSLASH) begin
          st_mid = bsl_pkg::ST_ESC_SQ;
        end
      end
      bsl_pkg::ST_ESC_DQ: begin
        st_mid = bsl_pkg::ST_STR_DQ;
      end
      bsl_pkg::ST_ESC_SQ: begin
        st_mid = bsl_pkg::ST_STR_SQ;
      end
      bsl_pkg::ST_DASH: begin
        if (data_byte == bsl_pkg::CH_GT) begin
          e1     = 1'b1;
          r1     = mk_rec(bsl_pkg::KIND_ARROW, ts_r, pos1);
          st_mid = bsl_pkg::ST_IDLE;
        end else begin
          relex = 1'b1;
        end
      end
      bsl_pkg::ST_LBRACE: begin
        if (data_byte == bsl_pkg::CH_LBRACE) begin
          st_mid  = bsl_pkg::ST_SEL;
          dep_mid = DEP_OPEN;
        end else begin
          relex = 1'b1;
        end
      end
      bsl_pkg::ST_SEL: begin
        if (data_byte == bsl_pkg::CH_LBRACE) begin
          if (dep_r < DEP_MAX) begin
            dep_mid = dep_r + DEP_W'(1);
          end
        end else if (data_byte == bsl_pkg::CH_RBRACE) begin
          if (dep_r != '0) begin
            dn = dep_r - DEP_W'(1);
          end
          dep_mid = dn;
          if (dn == '0) begin
            st_mid = bsl_pkg::ST_SEL_CLOSE;
          end
        end
      end
      bsl_pkg::ST_SEL_CLOSE: begin
        e1 = 1'b1;
        if (data_byte == bsl_pkg::CH_RBRACE) begin
          r1     = mk_rec(bsl_pkg::KIND_SELECTOR, ts_r, pos1);
          st_mid = bsl_pkg::ST_IDLE;
        end else begin
          r1    = mk_rec(bsl_pkg::KIND_SELECTOR, ts_r, pos0);
          relex = 1'b1;
        end
      end
      default: begin
        relex = 1'b1;
      end
    endcase

    // lex the byte afresh from idle
    if (relex) begin
      st_mid = bsl_pkg::ST_IDLE;
      if (!bsl_pkg::is_space(data_byte)) begin
        ts_mid = off_r;
        if (!mode_r) begin
          if (bsl_pkg::is_symbol(data_byte)) begin
            e2 = 1'b1;
            r2 = mk_rec(bsl_pkg::KIND_SYMBOL, off_r, pos1);
          end else if (data_byte == bsl_pkg::CH_DQUOTE) begin
            st_mid = bsl_pkg::ST_STR_DQ;
          end else if (data_byte == bsl_pkg::CH_SQUOTE) begin
            st_mid = bsl_pkg::ST_STR_SQ;
          end else if (bsl_pkg::is_id_start(data_byte)) begin
            st_mid  = bsl_pkg::ST_IDENT;
            kwp_mid = (data_byte == bsl_pkg::CH_V) ? bsl_pkg::KW_V : bsl_pkg::KW_MISS;
          end
        end else begin
          if (data_byte == bsl_pkg::CH_LBRACE) begin
            st_mid = bsl_pkg::ST_LBRACE;
          end else if (data_byte == bsl_pkg::CH_DASH) begin
            st_mid = bsl_pkg::ST_DASH;
          end else if (bsl_pkg::is_id_start(data_byte)) begin
            st_mid  = bsl_pkg::ST_IDENT;
            kwp_mid = (data_byte == bsl_pkg::CH_V) ? bsl_pkg::KW_V : bsl_pkg::KW_MISS;
          end
        end
      end
    end

    // flush an open token on the last byte of the fragment
    if (end_of_content) begin
      case (st_mid)
        bsl_pkg::ST_IDENT: begin
          e3 = 1'b1;
          r3 = mk_rec(ident_kind(mode_r, kwp_mid), ts_mid, pos1);
        end
        bsl_pkg::ST_STR_DQ, bsl_pkg::ST_STR_SQ,
        bsl_pkg::ST_ESC_DQ, bsl_pkg::ST_ESC_SQ: begin
          e3 = 1'b1;
          r3 = mk_rec(bsl_pkg::KIND_STRING, ts_mid, pos1);
        end
        bsl_pkg::ST_SEL, bsl_pkg::ST_SEL_CLOSE: begin
          e3 = 1'b1;
          r3 = mk_rec(bsl_pkg::KIND_SELECTOR, ts_mid, pos1);
        end
        default: begin
          e3 = 1'b0;
        end
      endcase
    end

    // a symbol from the relex and a flush never occur together
    second = e2 ? r2 : r3;
    has2   = e2 | e3;

    push.v0        = step_en & (e1 | has2);
    push.v1        = step_en & e1 & has2;
    push.rec0      = e1 ? r1 : second;
    push.rec0.last = !(e1 && has2);
    push.rec1      = second;
    push.rec1.last = 1'b1;

    if (end_of_content) begin
      st_nxt  = bsl_pkg::ST_IDLE;
      off_nxt = '0;
      ts_nxt  = '0;
      dep_nxt = '0;
      kwp_nxt = bsl_pkg::KW_NONE;
    end else begin
      st_nxt  = st_mid;
      off_nxt = (off_r == OFF_LAST) ? OFF_LAST : off_r + OFF_W'(1);
      ts_nxt  = ts_mid;
      dep_nxt = dep_mid;
      kwp_nxt = kwp_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= bsl_pkg::ST_IDLE;
      off_r <= '0;
      ts_r  <= '0;
      dep_r <= '0;
      kwp_r <= bsl_pkg::KW_NONE;
    end else if (step_en) begin
      st_r  <= st_nxt;
      off_r <= off_nxt;
      ts_r  <= ts_nxt;
      dep_r <= dep_nxt;
      kwp_r <= kwp_nxt;
    end
  end

endmodule

/* rtl/core/bsl_outq.sv */
// four-entry result queue, two writes and one read per cycle
module bsl_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsl_pkg::token_push_t push,
  input  logic                 pop_ready,
  output logic                 out_valid,
  output bsl_pkg::token_rec_t  out_rec,
  output logic                 room_for_two
);

  localparam int QD    = 4;
  localparam int PTR_W = $clog2(QD);

  bsl_pkg::token_rec_t mem_r [QD];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]      cnt_r, cnt_nxt;
  logic                pop;
  logic [PTR_W:0]      n_push;

  assign out_valid    = (cnt_r != '0);
  assign out_rec      = mem_r[rd_ptr_r];
  assign room_for_two = (cnt_r <= (PTR_W+1)'(QD - 2));
  assign pop          = out_valid & pop_ready;

  always_comb begin
    n_push     = (PTR_W+1)'(push.v0) + (PTR_W+1)'(push.v1);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + n_push - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.rec0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= push.rec1;
    end
  end

endmodule

/* rtl/core/two_mode_byte_stream_lexer.sv */
// top level of the two-mode byte stream lexer
// records are registered in the result queue and offered on out_valid in order of arrival
// throughput: one byte per cycle while in_ready; each gives up to two records, drained one per cycle while out_ready
// a four-entry result queue parts the sides; in_ready drops while fewer than two slots are free
// reset (rst_n low, synchronous): mode 0, scanner idle, offsets and depth cleared, queue empty
module two_mode_byte_stream_lexer #(
  parameter int MAX_CONTENT     = 65536,
  parameter int MAX_BRACE_DEPTH = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: lexer_mode register
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // byte input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_content,
  // token record channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_kind,
  output logic [15:0] out_start_offset,
  output logic [16:0] out_token_length,
  output logic        out_last_of_run
);

  bsl_pkg::token_push_t push;
  bsl_pkg::token_rec_t  head_rec;
  logic                 room_for_two;
  logic                 step_en;

  // a byte transaction advances the scanner
  assign in_ready = room_for_two;
  assign step_en  = in_valid & in_ready;

  // scanner: state registers plus the per-byte next-state logic
  bsl_core #(
    .MAX_CONTENT     (MAX_CONTENT),
    .MAX_BRACE_DEPTH (MAX_BRACE_DEPTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .step_en        (step_en),
    .data_byte      (in_data_byte),
    .end_of_content (in_end_of_content),
    .push           (push)
  );

  // records wait here until the consumer takes them, in order
  bsl_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .pop_ready    (out_ready),
    .out_valid    (out_valid),
    .out_rec      (head_rec),
    .room_for_two (room_for_two)
  );

  assign out_token_kind   = head_rec.kind;
  assign out_start_offset = head_rec.start;
  assign out_token_length = head_rec.len;
  assign out_last_of_run  = head_rec.last;

endmodule

/* rtl/core/bsl_checker.sv */
// port-level checks for the byte stream lexer and their binding
module bsl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_token_kind,
  input logic [15:0] out_start_offset,
  input logic [16:0] out_token_length,
  input logic        out_last_of_run
);

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_start_offset) && $stable(out_token_length) && $stable(out_last_of_run))
    else $error("stalled token record changed");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("record offered after reset");

  // an empty queue always takes a byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending records");

  // no record is empty and the kind is defined
  a_rec_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_length != 17'd0) && (out_token_kind <= 3'd5))
    else $error("malformed token record");

  // with an empty queue and no byte transaction, no record is offered the next cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("record appeared without a byte transaction");

endmodule

bind two_mode_byte_stream_lexer bsl_checker u_bsl_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_token_kind    (out_token_kind),
  .out_start_offset  (out_start_offset),
  .out_token_length  (out_token_length),
  .out_last_of_run   (out_last_of_run)
);
